### rtl/core/fas_pkg.sv
// Shared types and constants of the frame animation sequencer.
package fas_pkg;

  localparam int CMD_W    = 2;
  localparam int DELTA_W  = 16;
  localparam int ENTRY_W  = 6;
  localparam int DUR_W    = 16;
  localparam int FRAME_W  = 6;
  localparam int TIME_W   = 25;
  localparam int SPEED_W  = 12;
  localparam int COUNT_W  = 7;
  localparam int PROD_W   = DELTA_W + 1 + SPEED_W;
  localparam int SUM_W    = PROD_W + 1;

  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic signed [SPEED_W-1:0] SPEED_RESET = 12'sd256;
  localparam logic [COUNT_W-1:0]        COUNT_RESET = 7'd1;

  localparam logic signed [SUM_W-1:0] TIME_MAX = 30'sd16777215;
  localparam logic signed [SUM_W-1:0] TIME_MIN = -30'sd16777216;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_PLAY  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_SPEED = 2'd0,
    REG_LOOP  = 2'd1,
    REG_COUNT = 2'd2
  } cfg_reg_e;

endpackage

### rtl/core/fas_in_if.sv
// Request channel carrying one command item into the sequencer.
interface fas_in_if;
  logic                         valid;
  logic                         ready;
  logic [fas_pkg::CMD_W-1:0]    cmd;
  logic [fas_pkg::DELTA_W-1:0]  delta;
  logic [fas_pkg::ENTRY_W-1:0]  entry_index;
  logic [fas_pkg::DUR_W-1:0]    duration;

  modport source (output valid, output cmd, output delta, output entry_index,
                  output duration, input ready);
  modport sink   (input valid, input cmd, input delta, input entry_index,
                  input duration, output ready);
endinterface

### rtl/core/fas_out_if.sv
// Result channel carrying the animation state after each request.
interface fas_out_if;
  logic                               valid;
  logic                               ready;
  logic [fas_pkg::FRAME_W-1:0]        current_frame;
  logic signed [fas_pkg::TIME_W-1:0]  frame_time;
  logic                               playing;

  modport source (output valid, output current_frame, output frame_time,
                  output playing, input ready);
  modport sink   (input valid, input current_frame, input frame_time,
                  input playing, output ready);
endinterface

### rtl/core/fas_dur_mem.sv
// Frame duration memory: one write port, one registered read port with write forwarding.
module fas_dur_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [fas_pkg::DUR_W-1:0]   wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [fas_pkg::DUR_W-1:0]   rdata_o
);

  logic [fas_pkg::DUR_W-1:0] mem_q [DEPTH];
  logic [fas_pkg::DUR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // bypass a same-cycle write so the read never sees stale data
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/frame_animation_sequencer_core.sv
// Top level of the frame animation sequencer: config, issue stage, execute stage and result register.
//
// Usage: requests enter on in_i (valid/ready). Each request is a tick (advance the frame
// timer by delta * speed), a play (restart at frame 0 and run) or a duration write into
// the frame table. Every accepted request returns exactly one result on out_o: the frame
// index, the frame timer (1/256 tick units) and the playing flag after the request.
// Throughput is one request per cycle while out_o is not stalled. A request is first
// registered with its delta * speed product in the issue stage; executing it applies it to the
// state registers and loads the result register. The duration memory is read every cycle
// at the frame index that becomes current, so the registered read data always holds the
// current frame's duration when a tick executes; writes to that entry are forwarded.
// Speed, loop enable and frame count sit in APB registers at byte addresses 0, 4 and 8;
// write them only while no request is in flight.
// Reset clears frame, timer and playing and loads speed 1.0, no looping, one frame.
// The duration table is not cleared: write an entry before playing through it.
// When out_o stalls, the result holds, the issue stage still takes a request if it is empty,
// and in_i.ready then stays low until the result is taken.
module frame_animation_sequencer_core #(
  parameter int MAX_FRAMES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fas_in_if.sink                        in_i,
  fas_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fas_pkg::APB_AW-1:0]    paddr,
  input  logic [fas_pkg::APB_DW-1:0]    pwdata,
  output logic [fas_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  // wide enough for frame counts, MAX_FRAMES itself and index + 1
  localparam int CMP_W = (IDX_W + 1 > fas_pkg::COUNT_W) ? IDX_W + 1 : fas_pkg::COUNT_W;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_FRAMES);
  localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [fas_pkg::SPEED_W-1:0] speed_q;
  logic                               loop_q;
  logic [fas_pkg::COUNT_W-1:0]        count_q;
  logic                               cfg_wr;
  fas_pkg::cfg_reg_e                  cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = fas_pkg::cfg_reg_e'(paddr[fas_pkg::APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= fas_pkg::SPEED_RESET;
      loop_q  <= 1'b0;
      count_q <= fas_pkg::COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        fas_pkg::REG_SPEED: speed_q <= pwdata[fas_pkg::SPEED_W-1:0];
        fas_pkg::REG_LOOP:  loop_q  <= pwdata[0];
        fas_pkg::REG_COUNT: count_q <= pwdata[fas_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      fas_pkg::REG_SPEED: prdata = {{(fas_pkg::APB_DW-fas_pkg::SPEED_W){1'b0}}, speed_q};
      fas_pkg::REG_LOOP:  prdata = {{(fas_pkg::APB_DW-1){1'b0}}, loop_q};
      fas_pkg::REG_COUNT: prdata = {{(fas_pkg::APB_DW-fas_pkg::COUNT_W){1'b0}}, count_q};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Issue stage: hold the request and its delta * speed product
  // ---------------------------------------------------------------------------
  logic                                s1_v_q;
  logic [fas_pkg::CMD_W-1:0]           s1_cmd_q;
  logic signed [fas_pkg::PROD_W-1:0]   s1_prod_q;
  logic [fas_pkg::ENTRY_W-1:0]         s1_entry_q;
  logic [fas_pkg::DUR_W-1:0]           s1_dur_q;
  logic signed [fas_pkg::PROD_W-1:0]   prod_d;
  logic                                in_acc;
  logic                                exe_go;
  logic                                out_v_q;

  assign prod_d     = $signed({1'b0, in_i.delta}) * speed_q;
  assign in_acc     = in_i.valid & in_i.ready;
  assign exe_go     = s1_v_q & (~out_v_q | out_o.ready);
  assign in_i.ready = ~s1_v_q | exe_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_acc) begin
      s1_v_q <= 1'b1;
    end else if (exe_go) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q   <= in_i.cmd;
      s1_prod_q  <= prod_d;
      s1_entry_q <= in_i.entry_index;
      s1_dur_q   <= in_i.duration;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute stage: read-modify-write of frame state
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]                   frame_q, frame_d;
  logic signed [fas_pkg::TIME_W-1:0]  timer_q, timer_d;
  logic                               run_q, run_d;
  logic [fas_pkg::DUR_W-1:0]          dur_rd;
  logic                               dur_we;
  logic [IDX_W-1:0]                   dur_waddr;

  logic [CMP_W-1:0]                   count_ext, n_frames, last_c, f_ext, inc_c, dec_c;
  logic [CMP_W-1:0]                   entry_ext;
  logic signed [fas_pkg::SUM_W-1:0]   sum_w;
  logic signed [fas_pkg::TIME_W-1:0]  t_sat;
  logic signed [fas_pkg::TIME_W:0]    t_ext, limit_w;
  logic                               frame_end;

  // frame count 0 acts as one frame, counts above the table act as the table size
  assign count_ext = CMP_W'(count_q);
  assign n_frames  = (count_ext == '0) ? ONE_C : ((count_ext > MAX_C) ? MAX_C : count_ext);
  assign last_c    = n_frames - ONE_C;
  assign f_ext     = CMP_W'(frame_q);
  assign inc_c     = f_ext + ONE_C;
  assign dec_c     = f_ext - ONE_C;
  assign entry_ext = CMP_W'(s1_entry_q);
  assign dur_waddr = IDX_W'(entry_ext);

  // saturating timer add
  assign sum_w = fas_pkg::SUM_W'(timer_q) + fas_pkg::SUM_W'(s1_prod_q);
  always_comb begin
    if (sum_w > fas_pkg::TIME_MAX) begin
      t_sat = fas_pkg::TIME_W'(fas_pkg::TIME_MAX);
    end else if (sum_w < fas_pkg::TIME_MIN) begin
      t_sat = fas_pkg::TIME_W'(fas_pkg::TIME_MIN);
    end else begin
      t_sat = sum_w[fas_pkg::TIME_W-1:0];
    end
  end

  assign t_ext     = (fas_pkg::TIME_W+1)'(t_sat);
  assign limit_w   = $signed({2'b00, dur_rd, 8'h00});
  assign frame_end = (t_ext >= limit_w) || (t_sat < 0);

  always_comb begin
    frame_d = frame_q;
    timer_d = timer_q;
    run_d   = run_q;
    dur_we  = 1'b0;
    if (exe_go) begin
      case (s1_cmd_q)
        fas_pkg::CMD_TICK: begin
          if (run_q) begin
            timer_d = t_sat;
            if (frame_end) begin
              timer_d = '0;
              if (!speed_q[fas_pkg::SPEED_W-1]) begin
                // forward step; running off the end wraps or clamps and stops
                if (inc_c >= n_frames) begin
                  if (loop_q) begin
                    frame_d = '0;
                  end else begin
                    frame_d = IDX_W'(last_c);
                    run_d   = 1'b0;
                  end
                end else begin
                  frame_d = IDX_W'(inc_c);
                end
              end else if (f_ext == '0) begin
                if (loop_q) begin
                  frame_d = IDX_W'(last_c);
                end else begin
                  run_d = 1'b0;
                end
              end else if (dec_c >= n_frames) begin
                // index was left beyond a lowered count
                if (loop_q) begin
                  frame_d = '0;
                end else begin
                  frame_d = IDX_W'(last_c);
                  run_d   = 1'b0;
                end
              end else begin
                frame_d = IDX_W'(dec_c);
              end
            end
          end
        end
        fas_pkg::CMD_PLAY: begin
          frame_d = '0;
          timer_d = '0;
          run_d   = 1'b1;
        end
        fas_pkg::CMD_WRITE: begin
          // drop writes past the table
          dur_we = (entry_ext < MAX_C);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      timer_q <= '0;
      run_q   <= 1'b0;
    end else begin
      frame_q <= frame_d;
      timer_q <= timer_d;
      run_q   <= run_d;
    end
  end

  // read at the upcoming frame index so the data lines up with frame_q next cycle
  fas_dur_mem #(
    .DEPTH (MAX_FRAMES),
    .AW    (IDX_W)
  ) u_dur_mem (
    .clk_i   (clk_i),
    .we_i    (dur_we),
    .waddr_i (dur_waddr),
    .wdata_i (s1_dur_q),
    .raddr_i (frame_d),
    .rdata_o (dur_rd)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [fas_pkg::FRAME_W-1:0]        out_frame_q;
  logic signed [fas_pkg::TIME_W-1:0]  out_time_q;
  logic                               out_play_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (exe_go) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exe_go) begin
      out_frame_q <= fas_pkg::FRAME_W'(frame_d);
      out_time_q  <= timer_d;
      out_play_q  <= run_d;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.current_frame = out_frame_q;
  assign out_o.frame_time    = out_time_q;
  assign out_o.playing       = out_play_q;

endmodule

### rtl/core/fas_checker.sv
// Port-level checks of the frame animation sequencer, bound to its top level.
module fas_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [fas_pkg::FRAME_W-1:0]        current_frame_i,
  input logic signed [fas_pkg::TIME_W-1:0]  frame_time_i,
  input logic                               playing_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(current_frame_i)
      && $stable(frame_time_i) && $stable(playing_i))
    else $error("stalled result changed");

  // with no result pending the block takes a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("request blocked with empty result register");

  // a negative timer always ends the frame, so results never show one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !frame_time_i[fas_pkg::TIME_W-1])
    else $error("negative frame time");

  // stopping only happens at a frame end, which clears the timer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !playing_i |-> frame_time_i == '0)
    else $error("stopped with nonzero frame time");

endmodule

bind frame_animation_sequencer_core fas_checker u_fas_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .current_frame_i (out_o.current_frame),
  .frame_time_i    (out_o.frame_time),
  .playing_i       (out_o.playing)
);
